[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds whenever reset is low
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication a |=> b outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/abcm_pkg.sv]
// Shared types and constants of the ARP binding monitor
package abcm_pkg;
  localparam int TableSlotsDefault = 64;
  localparam int IndexWidth = 6;
  localparam logic [15:0] MinFrameReset = 16'd42;
  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply = 16'd2;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_SHORT = 3'd1,
    ST_NEW = 3'd2,
    ST_REFRESH = 3'd3,
    ST_CONFLICT = 3'd4,
    ST_FULL = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_REPLY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    JOB_CLEAR = 2'd0,
    JOB_SKIP = 2'd1,
    JOB_LOOKUP = 2'd2
  } job_t;

  // Classified item handed from front to back
  typedef struct packed {
    job_t job;
    status_t status;
    logic gratuitous;
    kind_t op_kind;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } work_t;

  typedef struct packed {
    status_t status;
    logic gratuitous;
    kind_t op_kind;
    logic [47:0] previous_mac;
    logic [IndexWidth-1:0] entry_index;
    logic [31:0] entry_hits;
    logic [31:0] total_packets;
    logic [31:0] request_total;
    logic [31:0] reply_total;
    logic [31:0] gratuitous_total;
    logic [31:0] conflict_total;
  } result_t;
endpackage

[rtl/abcm_front.sv]
// Front end: classify items and feed a two-entry work queue
module abcm_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic enable,
  input  logic [15:0] min_len,
  input  logic command,
  input  logic [15:0] arp_operation,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic [31:0] target_ip,
  input  logic [15:0] frame_length,
  output logic work_valid,
  output abcm_pkg::work_t work,
  input  logic work_take
);
  abcm_pkg::work_t q [2];
  logic rd, wr;
  logic [1:0] count;
  abcm_pkg::work_t cls;
  logic take_in;

  always_comb begin
    cls.sender_ip = sender_ip;
    cls.sender_mac = sender_mac;
    cls.gratuitous = 1'b0;
    cls.op_kind = abcm_pkg::KIND_OTHER;
    cls.status = abcm_pkg::ST_DISABLED;
    cls.job = abcm_pkg::JOB_SKIP;
    if (command) begin
      cls.job = abcm_pkg::JOB_CLEAR;
      cls.status = abcm_pkg::ST_CLEARED;
    end else if (!enable) begin
      cls.status = abcm_pkg::ST_DISABLED;
    end else if (frame_length < min_len) begin
      cls.status = abcm_pkg::ST_SHORT;
    end else begin
      cls.job = abcm_pkg::JOB_LOOKUP;
      cls.status = abcm_pkg::ST_NEW;
      cls.gratuitous = (sender_ip == target_ip);
      if (arp_operation == abcm_pkg::OpRequest) cls.op_kind = abcm_pkg::KIND_REQUEST;
      else if (arp_operation == abcm_pkg::OpReply) cls.op_kind = abcm_pkg::KIND_REPLY;
    end
  end

  assign full = (count == 2'd2);
  assign take_in = push && !full;
  assign work_valid = (count != 2'd0);
  assign work = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (take_in) begin
        q[wr] <= cls;
        wr <= ~wr;
      end
      if (work_take && work_valid) rd <= ~rd;
      count <= count + {1'b0, take_in} - {1'b0, work_take && work_valid};
    end
  end
endmodule

[rtl/abcm_back.sv]
// Back end: table search, update and counters, one item at a time
module abcm_back #(
  parameter int TableSlots = abcm_pkg::TableSlotsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic work_valid,
  input  abcm_pkg::work_t work,
  output logic work_take,
  output logic res_valid,
  output abcm_pkg::result_t res,
  input  logic res_take
);
  localparam int SW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int CW = $clog2(TableSlots + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_WRITE, S_DONE} state_t;
  state_t state;

  logic [TableSlots-1:0] valid;
  logic [31:0] mem_ip [TableSlots];
  logic [47:0] mem_mac [TableSlots];
  logic [31:0] mem_hits [TableSlots];
  logic mem_suspect [TableSlots];
  logic [31:0] rd_ip, rd_hits;
  logic [47:0] rd_mac;

  abcm_pkg::work_t cur;
  abcm_pkg::result_t acc;
  logic [CW-1:0] scan;
  logic [SW-1:0] slot;
  logic [CW-1:0] free_slot;
  logic have_free;
  logic [CW-1:0] occupied;
  logic [31:0] c_pkt, c_req, c_rep, c_grat, c_conf;
  logic wr_en, wr_new;
  logic [SW-1:0] wr_slot;

  assign work_take = (state == S_IDLE) && work_valid;

  always_ff @(posedge clk) begin
    rd_ip <= mem_ip[slot];
    rd_mac <= mem_mac[slot];
    rd_hits <= mem_hits[slot];
    if (wr_en) begin
      mem_mac[wr_slot] <= cur.sender_mac;
      mem_ip[wr_slot] <= cur.sender_ip;
      mem_hits[wr_slot] <= wr_new ? 32'd1 : rd_hits + 32'd1;
      if (wr_new || rd_mac != cur.sender_mac) mem_suspect[wr_slot] <= !wr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      occupied <= '0;
      res_valid <= 1'b0;
      c_pkt <= '0; c_req <= '0; c_rep <= '0; c_grat <= '0; c_conf <= '0;
      wr_en <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (res_valid && res_take && state != S_DONE) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (work_valid) begin
            cur <= work;
            acc.status <= work.status;
            acc.gratuitous <= work.gratuitous;
            acc.op_kind <= work.op_kind;
            acc.previous_mac <= '0;
            acc.entry_index <= '0;
            acc.entry_hits <= '0;
            scan <= '0;
            slot <= '0;
            have_free <= 1'b0;
            free_slot <= '0;
            case (work.job)
              abcm_pkg::JOB_CLEAR: begin
                valid <= '0;
                occupied <= '0;
                state <= S_DONE;
              end
              abcm_pkg::JOB_LOOKUP: begin
                c_pkt <= c_pkt + 32'd1;
                if (work.op_kind == abcm_pkg::KIND_REQUEST) c_req <= c_req + 32'd1;
                if (work.op_kind == abcm_pkg::KIND_REPLY) c_rep <= c_rep + 32'd1;
                if (work.gratuitous) c_grat <= c_grat + 32'd1;
                state <= S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (valid[slot] && rd_ip == cur.sender_ip) begin
            acc.entry_index <= abcm_pkg::IndexWidth'(scan);
            acc.entry_hits <= rd_hits + 32'd1;
            if (rd_mac != cur.sender_mac) begin
              acc.status <= abcm_pkg::ST_CONFLICT;
              acc.previous_mac <= rd_mac;
              c_conf <= c_conf + 32'd1;
            end else begin
              acc.status <= abcm_pkg::ST_REFRESH;
            end
            wr_en <= 1'b1;
            wr_new <= 1'b0;
            wr_slot <= slot;
            state <= S_WRITE;
          end else begin
            if (!valid[slot] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= scan;
            end
            if (scan == CW'(TableSlots - 1)) begin
              state <= S_WRITE;
              if (!valid[slot] || have_free) begin
                wr_en <= 1'b1;
                wr_new <= 1'b1;
                wr_slot <= (!valid[slot] && !have_free) ? slot : free_slot[SW-1:0];
                valid[(!valid[slot] && !have_free) ? slot : free_slot[SW-1:0]] <= 1'b1;
                occupied <= occupied + 1'b1;
                acc.status <= abcm_pkg::ST_NEW;
                acc.entry_index <= (!valid[slot] && !have_free)
                  ? abcm_pkg::IndexWidth'(scan) : abcm_pkg::IndexWidth'(free_slot);
                acc.entry_hits <= 32'd1;
              end else begin
                acc.status <= abcm_pkg::ST_FULL;
              end
            end else begin
              scan <= scan + 1'b1;
              slot <= slot + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (!res_valid || res_take) begin
            res_valid <= 1'b1;
            res.status <= acc.status;
            res.gratuitous <= acc.gratuitous;
            res.op_kind <= acc.op_kind;
            res.previous_mac <= acc.previous_mac;
            res.entry_index <= acc.entry_index;
            res.entry_hits <= acc.entry_hits;
            res.total_packets <= c_pkt;
            res.request_total <= c_req;
            res.reply_total <= c_rep;
            res.gratuitous_total <= c_grat;
            res.conflict_total <= c_conf;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/arp_binding_conflict_monitor.sv]
// Top level of the ARP binding monitor
// Usage:
//   Input channel: queue style, push and full; an item is taken when push is
//   high and full is low. command 1 clears the binding table.
//   Result channel: queue style, empty and pop; the result is on the ports
//   while empty is low and leaves when pop is high.
//   Config port: cfg_we, cfg_index, cfg_data; index 0 monitor_enable,
//   index 1 min_frame_length. Write only while the block is idle.
// Flow:
//   A two-entry queue sits between the classifier and the table engine.
//   A table lookup walks the slots in turn through the slot memory read
//   port and stops at a matching slot; the engine takes one item at a time.
//   Clear, disabled and short-frame items skip the table walk.
// Reset: table empty, counters zero, monitor enabled, min length 42.
// Stall: when pop stays low the held result blocks the engine; the queue
//   then fills and full rises.
module arp_binding_conflict_monitor #(
  parameter int TableSlots = abcm_pkg::TableSlotsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic command,
  input  logic [15:0] arp_operation,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic [31:0] target_ip,
  input  logic [15:0] frame_length,
  output logic empty,
  input  logic pop,
  output logic [2:0] status,
  output logic gratuitous,
  output logic [1:0] op_kind,
  output logic [47:0] previous_mac,
  output logic [5:0] entry_index,
  output logic [31:0] entry_hits,
  output logic [31:0] total_packets,
  output logic [31:0] request_total,
  output logic [31:0] reply_total,
  output logic [31:0] gratuitous_total,
  output logic [31:0] conflict_total,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
  logic enable;
  logic [15:0] min_len;
  logic work_valid, work_take, res_valid;
  abcm_pkg::work_t work;
  abcm_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      min_len <= abcm_pkg::MinFrameReset;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) enable <= cfg_data[0];
      else min_len <= cfg_data;
    end
  end

  abcm_front u_front (
    .clk, .rst, .push, .full, .enable, .min_len, .command, .arp_operation,
    .sender_ip, .sender_mac, .target_ip, .frame_length,
    .work_valid, .work, .work_take
  );

  abcm_back #(.TableSlots(TableSlots)) u_back (
    .clk, .rst, .work_valid, .work, .work_take, .res_valid, .res,
    .res_take(pop)
  );

  assign empty = !res_valid;
  assign status = res.status;
  assign gratuitous = res.gratuitous;
  assign op_kind = res.op_kind;
  assign previous_mac = res.previous_mac;
  assign entry_index = res.entry_index;
  assign entry_hits = res.entry_hits;
  assign total_packets = res.total_packets;
  assign request_total = res.request_total;
  assign reply_total = res.reply_total;
  assign gratuitous_total = res.gratuitous_total;
  assign conflict_total = res.conflict_total;
endmodule

[rtl/abcm_checker.sv]
// Port checker for the ARP binding monitor
`include "assert_macros.svh"
module abcm_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [2:0] status,
  input logic [47:0] previous_mac,
  input logic [31:0] entry_hits
);
  `CHK_ALWAYS(a_status_range, clk, rst, empty || status <= abcm_pkg::ST_CLEARED, "status out of range")
  `CHK_ALWAYS(a_prev_mac, clk, rst, empty || status == abcm_pkg::ST_CONFLICT || previous_mac == 48'd0, "previous_mac without conflict")
  `CHK_ALWAYS(a_new_hits, clk, rst, empty || status != abcm_pkg::ST_NEW || entry_hits == 32'd1, "new binding hits not one")
  `CHK_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(status), "result dropped while stalled")
endmodule

bind arp_binding_conflict_monitor abcm_checker u_abcm_checker (
  .clk, .rst, .empty, .pop, .status, .previous_mac, .entry_hits
);

[bench/arp_binding_conflict_monitor_test.sv]
// Self-checking testbench of the ARP binding monitor: random and directed items, scoreboard
module arp_binding_conflict_monitor_test;

  typedef struct {
    logic        command;
    logic [15:0] arp_operation;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [15:0] frame_length;
  } packet_t;

  class binding_scoreboard;
    bit          enable;
    logic [15:0] min_len;
    bit          valid [64];
    logic [31:0] ip [64];
    logic [47:0] mac [64];
    logic [31:0] hits [64];
    logic [31:0] n_pkt, n_req, n_rep, n_grat, n_conf;
    abcm_pkg::result_t pending [$];
    int          errors;

    function void reset_state();
      enable = 1;
      min_len = abcm_pkg::MinFrameReset;
      foreach (valid[i]) valid[i] = 0;
      n_pkt = 0; n_req = 0; n_rep = 0; n_grat = 0; n_conf = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void note_packet(packet_t p);
      abcm_pkg::result_t r;
      int slot;
      r = '0;
      slot = -1;
      if (p.command) begin
        foreach (valid[i]) valid[i] = 0;
        r.status = abcm_pkg::ST_CLEARED;
      end else if (!enable) begin
        r.status = abcm_pkg::ST_DISABLED;
      end else if (p.frame_length < min_len) begin
        r.status = abcm_pkg::ST_SHORT;
      end else begin
        n_pkt++;
        if (p.arp_operation == abcm_pkg::OpRequest) begin
          r.op_kind = abcm_pkg::KIND_REQUEST;
          n_req++;
        end else if (p.arp_operation == abcm_pkg::OpReply) begin
          r.op_kind = abcm_pkg::KIND_REPLY;
          n_rep++;
        end
        if (p.sender_ip == p.target_ip) begin
          r.gratuitous = 1;
          n_grat++;
        end
        for (int i = 0; i < 64; i++)
          if (slot < 0 && valid[i] && ip[i] == p.sender_ip) slot = i;
        if (slot >= 0) begin
          hits[slot]++;
          if (mac[slot] != p.sender_mac) begin
            r.previous_mac = mac[slot];
            mac[slot] = p.sender_mac;
            n_conf++;
            r.status = abcm_pkg::ST_CONFLICT;
          end else begin
            r.status = abcm_pkg::ST_REFRESH;
          end
          r.entry_index = 6'(slot);
          r.entry_hits = hits[slot];
        end else begin
          for (int i = 0; i < 64; i++)
            if (slot < 0 && !valid[i]) slot = i;
          if (slot >= 0) begin
            valid[slot] = 1;
            ip[slot] = p.sender_ip;
            mac[slot] = p.sender_mac;
            hits[slot] = 1;
            r.status = abcm_pkg::ST_NEW;
            r.entry_index = 6'(slot);
            r.entry_hits = 1;
          end else begin
            r.status = abcm_pkg::ST_FULL;
          end
        end
      end
      r.total_packets = n_pkt;
      r.request_total = n_req;
      r.reply_total = n_rep;
      r.gratuitous_total = n_grat;
      r.conflict_total = n_conf;
      pending.push_back(r);
    endfunction

    function void check_result(abcm_pkg::result_t got);
      abcm_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic command = 0;
  logic [15:0] arp_operation = '0;
  logic [31:0] sender_ip = '0;
  logic [47:0] sender_mac = '0;
  logic [31:0] target_ip = '0;
  logic [15:0] frame_length = '0;
  logic empty;
  logic pop = 0;
  logic [2:0] status;
  logic gratuitous;
  logic [1:0] op_kind;
  logic [47:0] previous_mac;
  logic [5:0] entry_index;
  logic [31:0] entry_hits, total_packets, request_total, reply_total;
  logic [31:0] gratuitous_total, conflict_total;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_data = '0;

  binding_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  logic [31:0] ip_pool [8];
  logic [47:0] mac_pool [4];

  always #5 clk = ~clk;

  arp_binding_conflict_monitor i_dut (
    .clk, .rst, .push, .full, .command, .arp_operation, .sender_ip, .sender_mac,
    .target_ip, .frame_length, .empty, .pop, .status, .gratuitous, .op_kind,
    .previous_mac, .entry_index, .entry_hits, .total_packets, .request_total,
    .reply_total, .gratuitous_total, .conflict_total, .cfg_we, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_result('{abcm_pkg::status_t'(status), gratuitous,
                           abcm_pkg::kind_t'(op_kind), previous_mac,
                           entry_index, entry_hits, total_packets, request_total,
                           reply_total, gratuitous_total, conflict_total});
    pop <= !rst && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_packet(packet_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    command <= p.command;
    arp_operation <= p.arp_operation;
    sender_ip <= p.sender_ip;
    sender_mac <= p.sender_mac;
    target_ip <= p.target_ip;
    frame_length <= p.frame_length;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_packet(p);
  endtask

  task automatic drain();
    push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [15:0] value);
    drain();
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    if (index) board.min_len = value;
    else board.enable = value[0];
  endtask

  function automatic packet_t make_packet(logic cmd, logic [15:0] op, logic [31:0] sip,
                                          logic [47:0] smac, logic [31:0] tip,
                                          logic [15:0] flen);
    packet_t p;
    p = '{cmd, op, sip, smac, tip, flen};
    return p;
  endfunction

  function automatic packet_t random_packet();
    packet_t p;
    int pick;
    pick = $urandom_range(99);
    p.command = (pick < 2);
    p.arp_operation = (pick < 40) ? abcm_pkg::OpRequest
                    : (pick < 80) ? abcm_pkg::OpReply : 16'($urandom);
    p.sender_ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(7)];
    p.sender_mac = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                           : mac_pool[$urandom_range(3)];
    p.target_ip = ($urandom_range(4) == 0) ? p.sender_ip : $urandom;
    p.frame_length = ($urandom_range(9) == 0) ? 16'($urandom_range(41))
                                             : 16'($urandom_range(42, 65535));
    return p;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) send_packet(random_packet());
  endtask

  initial begin
    #20_000_000;
    $display("FAIL arp_binding_conflict_monitor");
    $finish;
  end

  initial begin
    board.reset_state();
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_packet(make_packet(1'b0, abcm_pkg::OpRequest, 32'h0A000001, 48'h1, 32'h0A000002,
                            16'd42));
    send_packet(make_packet(1'b0, abcm_pkg::OpReply, 32'h0A000001, 48'h1, 32'h0A000001,
                            16'hFFFF));
    send_packet(make_packet(1'b0, 16'hFFFF, 32'h0A000001, 48'hFFFF_FFFF_FFFF, 32'h0, 16'd100));
    send_packet(make_packet(1'b0, 16'h0, 32'hFFFFFFFF, 48'h0, 32'hFFFFFFFF, 16'd41));
    send_packet(make_packet(1'b0, 16'h0, 32'h0, 48'h0, 32'h0, 16'd60));
    send_packet(make_packet(1'b1, 16'hFFFF, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 32'h1, 16'h0));
    send_packet(make_packet(1'b0, abcm_pkg::OpRequest, 32'h0A000001, 48'h2, 32'h5, 16'd60));
    for (int i = 0; i < 66; i++)
      send_packet(make_packet(1'b0, abcm_pkg::OpRequest, 32'hC0A80000 + i,
                              {16'h0, $urandom}, $urandom, 16'd64));
    write_reg(1'b0, 16'h0);
    send_packet(make_packet(1'b0, abcm_pkg::OpRequest, 32'h1, 48'h1, 32'h1, 16'd64));
    send_packet(make_packet(1'b1, 16'h0, 32'h0, 48'h0, 32'h0, 16'd0));
    write_reg(1'b0, 16'hFFFF);
    write_reg(1'b1, 16'hFFFF);
    send_packet(make_packet(1'b0, abcm_pkg::OpReply, 32'h1, 48'h1, 32'h2, 16'hFFFE));
    send_packet(make_packet(1'b0, abcm_pkg::OpReply, 32'h1, 48'h1, 32'h2, 16'hFFFF));
    write_reg(1'b1, 16'h0);
    send_packet(make_packet(1'b0, abcm_pkg::OpReply, 32'h2, 48'h1, 32'h2, 16'h0));
    write_reg(1'b1, abcm_pkg::MinFrameReset);

    random_run(400);
    send_idle_pct = 47;
    random_run(300);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    random_run(300);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    random_run(300);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    fork
      begin
        hold_off = 1;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      random_run(20);
    join
    drain();
    write_reg(1'b0, 16'h0);
    random_run(30);
    write_reg(1'b0, 16'h1);
    write_reg(1'b1, 16'd100);
    random_run(200);

    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS arp_binding_conflict_monitor");
    else
      $display("FAIL arp_binding_conflict_monitor");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/abcm_pkg.sv
rtl/abcm_front.sv
rtl/abcm_back.sv
rtl/arp_binding_conflict_monitor.sv
rtl/abcm_checker.sv
bench/arp_binding_conflict_monitor_test.sv
